### rtl/pidff_pkg.sv
`default_nettype none

package pidff_pkg;

    // Sample and fixed-point formats.
    localparam int ERROR_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SMOOTH_BITS = 16;
    localparam int DRIVE_W     = 32;

    // Configuration channel formats.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GAIN_W      = 32;
    localparam int SMOOTH_W    = SMOOTH_BITS + 1;
    localparam int LIMIT_W     = 31;

    // Register map.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN       = 3'd0,
        REG_INTEG_GAIN      = 3'd1,
        REG_DERIV_GAIN      = 3'd2,
        REG_FEEDFWD_GAIN    = 3'd3,
        REG_DERIV_SMOOTHING = 3'd4,
        REG_INTEG_LIMIT     = 3'd5
    } cfg_index_t;

endpackage

`default_nettype wire

### rtl/pidff_if.sv
`default_nettype none

// Error sample request channel.
interface pidff_in_if;
    import pidff_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [ERROR_WIDTH-1:0] error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface

// Controller output request channel.
interface pidff_out_if;
    import pidff_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// Register write request channel.
interface pidff_cfg_if;
    import pidff_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/positional_pid_with_feedforward.sv
`default_nettype none

// Positional PID controller with a low-pass filtered derivative and a
// feedforward term. Each error sample request produces one drive request.
// All products go through a single shared signed multiplier (33 bits by
// the filtered-difference width), which is used five times per sample
// under a small sequencer. A sample runs from acceptance to the drive value
// appearing in the output register through five multiply steps, one step
// to add the last product and one saturation step. The sequencer then
// returns to its idle state before it takes the next sample, so it takes
// no new sample until it is through with the last one. The sample channel
// is ready only while the sequencer is idle; a finished drive waits in the
// output register while the next sample is taken, and the sequencer holds
// in its last step only if an earlier drive is still unclaimed. Register
// writes are always accepted and must be issued while the controller is idle.
module positional_pid_with_feedforward (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pidff_in_if.sink    sample,
    pidff_out_if.source result,
    pidff_cfg_if.sink   cfg
);
    import pidff_pkg::*;

    // Derived internal widths.
    localparam int FD_W      = ERROR_WIDTH + SMOOTH_BITS + 2;
    localparam int A_W       = GAIN_W + 1;
    localparam int B_W       = (FD_W > 32) ? FD_W : 32;
    localparam int P_W       = A_W + B_W;
    localparam int ACC_W     = P_W + SMOOTH_BITS + 2;
    localparam int OUT_SHIFT = FRAC_BITS + SMOOTH_BITS;
    localparam int SUM_W     = 33;

    localparam logic [SMOOTH_W-1:0]   SMOOTH_ONE = SMOOTH_W'(1) << SMOOTH_BITS;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 33'sh1_8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DA,
        ST_MUL_FW,
        ST_MUL_PF,
        ST_MUL_KI,
        ST_MUL_KD,
        ST_ACC_KD,
        ST_SATURATE
    } state_t;

    state_t state_reg;

    logic signed [GAIN_W-1:0]      prop_gain_reg;
    logic signed [GAIN_W-1:0]      integ_gain_reg;
    logic signed [GAIN_W-1:0]      deriv_gain_reg;
    logic signed [GAIN_W-1:0]      feedfwd_gain_reg;
    logic        [SMOOTH_W-1:0]    smoothing_reg;
    logic        [LIMIT_W-1:0]     integ_limit_reg;

    logic signed [ERROR_WIDTH-1:0] error_reg;
    logic signed [ERROR_WIDTH-1:0] last_error_reg;
    logic signed [FD_W-1:0]        filt_diff_reg;
    logic signed [FD_W-1:0]        filt_tmp_reg;
    logic signed [DRIVE_W-1:0]     integ_sum_reg;
    logic signed [P_W-1:0]         prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [DRIVE_W-1:0]     drive_reg;
    logic                          out_valid_reg;

    logic signed [A_W-1:0]         op_a;
    logic signed [B_W-1:0]         op_b;
    logic signed [P_W-1:0]         prod_next;
    logic signed [A_W-1:0]         diff;
    logic signed [A_W-1:0]         gain_pf;
    logic        [SMOOTH_W-1:0]    weight_old;
    logic signed [SUM_W-1:0]       sum_raw;
    logic signed [SUM_W-1:0]       sum_sat;
    logic signed [SUM_W-1:0]       sum_lim;
    logic signed [SUM_W-1:0]       sum_clamped;
    logic signed [DRIVE_W-1:0]     integ_next;
    logic signed [FD_W-1:0]        filt_next;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       prod_scaled;
    logic signed [ACC_W-1:0]       acc_next;
    logic        [ACC_W-OUT_SHIFT-32:0] acc_top;
    logic signed [DRIVE_W-1:0]     drive_next;
    logic                          sample_take;
    logic                          out_free;

    assign sample.ready = (state_reg == ST_IDLE);
    assign sample_take  = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;
    assign out_free     = !out_valid_reg || result.ready;

    // Register writes; smoothing above one is held at one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            feedfwd_gain_reg <= '0;
            smoothing_reg    <= SMOOTH_ONE;
            integ_limit_reg  <= '1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_PROP_GAIN:       prop_gain_reg    <= signed'(cfg.data);
                REG_INTEG_GAIN:      integ_gain_reg   <= signed'(cfg.data);
                REG_DERIV_GAIN:      deriv_gain_reg   <= signed'(cfg.data);
                REG_FEEDFWD_GAIN:    feedfwd_gain_reg <= signed'(cfg.data);
                REG_DERIV_SMOOTHING:
                begin
                    if (cfg.data[SMOOTH_W-1:0] > SMOOTH_ONE)
                        smoothing_reg <= SMOOTH_ONE;
                    else
                        smoothing_reg <= cfg.data[SMOOTH_W-1:0];
                end
                REG_INTEG_LIMIT:     integ_limit_reg  <= cfg.data[LIMIT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Operand terms. Proportional and feedforward share one product since
    // both scale the raw error.
    assign diff       = A_W'(error_reg) - A_W'(last_error_reg);
    assign gain_pf    = A_W'(prop_gain_reg) + A_W'(feedfwd_gain_reg);
    assign weight_old = SMOOTH_ONE - smoothing_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_MUL_DA:
            begin
                op_a = diff;
                op_b = signed'(B_W'(smoothing_reg));
            end
            ST_MUL_FW:
            begin
                op_a = signed'(A_W'(weight_old));
                op_b = B_W'(filt_diff_reg);
            end
            ST_MUL_PF:
            begin
                op_a = gain_pf;
                op_b = B_W'(error_reg);
            end
            ST_MUL_KI:
            begin
                op_a = A_W'(integ_gain_reg);
                op_b = B_W'(integ_sum_reg);
            end
            ST_MUL_KD:
            begin
                op_a = A_W'(deriv_gain_reg);
                op_b = B_W'(filt_diff_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = P_W'(op_a) * P_W'(op_b);

    // Integral update: saturate to 32 bits, then clamp when the gain is set.
    always_comb
    begin
        sum_raw = SUM_W'(integ_sum_reg) + SUM_W'(error_reg);
        if (sum_raw > SUM_MAX)
            sum_sat = SUM_MAX;
        else if (sum_raw < SUM_MIN)
            sum_sat = SUM_MIN;
        else
            sum_sat = sum_raw;
        sum_lim     = signed'({2'b00, integ_limit_reg});
        sum_clamped = sum_sat;
        if (integ_gain_reg != '0)
        begin
            if (sum_sat > sum_lim)
                sum_clamped = sum_lim;
            else if (sum_sat < -sum_lim)
                sum_clamped = -sum_lim;
        end
        integ_next = sum_clamped[DRIVE_W-1:0];
    end

    // Filtered difference: new weighted difference plus the floored old share.
    assign filt_next = filt_tmp_reg + prod_reg[FD_W+SMOOTH_BITS-1:SMOOTH_BITS];

    // Accumulation of the output terms at the full product scale.
    assign prod_ext    = ACC_W'(prod_reg);
    assign prod_scaled = prod_ext <<< SMOOTH_BITS;

    always_comb
    begin
        unique case (state_reg)
            ST_MUL_KI: acc_next = prod_scaled;
            ST_MUL_KD: acc_next = acc_reg + prod_scaled;
            ST_ACC_KD: acc_next = acc_reg + prod_ext;
            default:   acc_next = acc_reg;
        endcase
    end

    // Output saturation: the integer part fits when the bits above it
    // all match the sign.
    assign acc_top = acc_reg[ACC_W-1:OUT_SHIFT+31];

    always_comb
    begin
        if ((&acc_top) || !(|acc_top))
            drive_next = acc_reg[OUT_SHIFT+DRIVE_W-1:OUT_SHIFT];
        else if (acc_reg[ACC_W-1])
            drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
        else
            drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
    end

    // Sequencer, controller state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            error_reg      <= '0;
            last_error_reg <= '0;
            filt_diff_reg  <= '0;
            filt_tmp_reg   <= '0;
            integ_sum_reg  <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            drive_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // A new drive takes the output register; otherwise a claimed one leaves.
            if (state_reg == ST_SATURATE && out_free)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;

            prod_reg <= prod_next;
            acc_reg  <= acc_next;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_take)
                    begin
                        error_reg <= sample.error_sample;
                        state_reg <= ST_MUL_DA;
                    end
                end
                ST_MUL_DA:
                begin
                    integ_sum_reg  <= integ_next;
                    last_error_reg <= error_reg;
                    state_reg      <= ST_MUL_FW;
                end
                ST_MUL_FW:
                begin
                    filt_tmp_reg <= prod_reg[FD_W-1:0];
                    state_reg    <= ST_MUL_PF;
                end
                ST_MUL_PF:
                begin
                    filt_diff_reg <= filt_next;
                    state_reg     <= ST_MUL_KI;
                end
                ST_MUL_KI:
                begin
                    state_reg <= ST_MUL_KD;
                end
                ST_MUL_KD:
                begin
                    state_reg <= ST_ACC_KD;
                end
                ST_ACC_KD:
                begin
                    state_reg <= ST_SATURATE;
                end
                ST_SATURATE:
                begin
                    if (out_free)
                    begin
                        drive_reg <= drive_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
